>>> sv/mcc_pkg.sv
// Package for the min-coin change solver: shared widths and codes.
// No dependencies.
package mcc_pkg;
    localparam int MAX_TARGET_DEF = 1023;
    localparam int NUM_COINS_DEF  = 6;
    localparam int REG_COINS      = 6;
    localparam int AMT_W          = 10;
    localparam int CNT_W          = 3;
    localparam int BEST_W         = 11;
    localparam logic [BEST_W-1:0] UNREACH = 11'h7FF;
    localparam logic [CNT_W-1:0] REG_COUNT = 3'd0;
endpackage

>>> sv/min_coin_change_solver.sv
// Top level of the min-coin change solver (unbounded supply, DP table).
// Depends on mcc_pkg.
//
//  channel  | valid     | stall     | payload
//  ---------+-----------+-----------+-------------------------------------
//  input    | in_valid  | in_stall  | target_amount
//  output   | out_valid | out_stall | coin_index, coin_uses, found, last
//  config   | cfg_we    | -         | cfg_index, cfg_data
//
// Steps: per amount 1..target, one read-issue state per coin, one more
// compare state when the coin fits, and one write state for best/choice
// (single-port memories, registered read); plus one write for amount 0.
// Then a backtrack read and a backtrack update state for each coin used,
// then count output transfers.
// One item at a time; in_stall is high while busy.
// Reset clears state and tallies, loads one coin of value 1; tables are
// never cleared, since each item writes entries from amount 0 up first.
// Output stall holds the current result in place.
module min_coin_change_solver
    import mcc_pkg::*;
#(
    parameter int MAX_TARGET = MAX_TARGET_DEF,
    parameter int NUM_COINS  = NUM_COINS_DEF
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [AMT_W-1:0] target_amount,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [CNT_W-1:0] coin_index,
    output logic [AMT_W-1:0] coin_uses,
    output logic             found,
    output logic             last,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_index,
    input  logic [AMT_W-1:0] cfg_data
);
    localparam int DEPTH = MAX_TARGET + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = AW + 1;   // extended amount width
    localparam int CW    = (EW > AMT_W) ? EW : AMT_W;   // coin vs amount compare width

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;   // issue read of best[a-c]
    localparam logic [2:0] S_CMP   = 3'd2;   // compare returned entry
    localparam logic [2:0] S_WR    = 3'd3;   // write best[a], choice[a]
    localparam logic [2:0] S_BTRD  = 3'd4;   // backtrack read
    localparam logic [2:0] S_BTUP  = 3'd5;   // backtrack update
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [BEST_W-1:0] best_mem [DEPTH];
    logic [CNT_W-1:0]  choice_mem [DEPTH];

    logic [CNT_W-1:0]  coin_count_reg;
    logic [AMT_W-1:0]  coin_value_reg [REG_COINS];
    logic [AMT_W-1:0]  tally_reg [REG_COINS];

    logic [2:0]        state_reg;
    logic [EW-1:0]     amt_reg;       // amount being filled
    logic [EW-1:0]     tgt_reg;
    logic [CNT_W-1:0]  k_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [BEST_W-1:0] b_reg;
    logic [CNT_W-1:0]  ch_reg;
    logic              found_reg;
    logic [AMT_W-1:0]  left_reg;

    // memory port signals
    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [BEST_W-1:0] mem_wbest;
    logic [CNT_W-1:0]  mem_wch;
    logic [BEST_W-1:0] rd_best;
    logic [CNT_W-1:0]  rd_ch;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            best_mem[mem_addr]   <= mem_wbest;
            choice_mem[mem_addr] <= mem_wch;
        end
        rd_best <= best_mem[mem_addr];
        rd_ch   <= choice_mem[mem_addr];
    end

    // effective coin count
    logic [CNT_W-1:0] n_eff;
    always_comb
    begin
        n_eff = coin_count_reg;
        if (int'(n_eff) > NUM_COINS) n_eff = CNT_W'(NUM_COINS);
        if (int'(n_eff) > REG_COINS) n_eff = CNT_W'(REG_COINS);
    end

    logic [AMT_W-1:0] cval;
    logic             cusable;
    logic [EW-1:0]    diff;
    logic [AMT_W-1:0] bt_val;
    always_comb
    begin
        cval    = (int'(k_reg) < REG_COINS) ? coin_value_reg[k_reg] : '0;
        cusable = (cval != '0) && (CW'(cval) <= CW'(amt_reg));
        diff    = amt_reg - EW'(cval);
        bt_val  = (int'(rd_ch) < REG_COINS) ? coin_value_reg[rd_ch] : '0;
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = amt_reg[AW-1:0];
        mem_wbest = b_reg;
        mem_wch   = ch_reg;
        case (state_reg)
            S_RD:    mem_addr = diff[AW-1:0];
            S_WR:    mem_we   = 1'b1;
            S_BTRD:  mem_addr = AW'(left_reg);
            default: mem_addr = amt_reg[AW-1:0];
        endcase
        if (state_reg == S_IDLE)
        begin
            mem_we    = 1'b0;
            mem_addr  = '0;
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = (state_reg == S_OUT);
    assign coin_index = k_reg;
    assign coin_uses  = found_reg ? tally_reg[k_reg] : '0;
    assign found      = found_reg;
    assign last       = (k_reg + 3'd1 == n_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coin_count_reg <= 3'd1;
            for (int i = 0; i < REG_COINS; i++)
            begin
                coin_value_reg[i] <= AMT_W'(1);
                tally_reg[i]      <= '0;
            end
            state_reg <= S_IDLE;
            amt_reg   <= '0;
            tgt_reg   <= '0;
            k_reg     <= '0;
            n_reg     <= '0;
            b_reg     <= '0;
            ch_reg    <= '0;
            found_reg <= 1'b0;
            left_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_COUNT)
                    coin_count_reg <= cfg_data[CNT_W-1:0];
                else if (int'(cfg_index) <= REG_COINS)
                    coin_value_reg[cfg_index - 3'd1] <= cfg_data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        for (int i = 0; i < REG_COINS; i++) tally_reg[i] <= '0;
                        n_reg     <= n_eff;
                        tgt_reg   <= EW'(target_amount);
                        found_reg <= 1'b0;
                        k_reg     <= '0;
                        if (n_eff == '0)
                            state_reg <= S_IDLE;
                        else if (int'(target_amount) > MAX_TARGET)
                            state_reg <= S_OUT;
                        else
                        begin
                            amt_reg   <= '0;
                            b_reg     <= '0;
                            ch_reg    <= '0;
                            state_reg <= S_WR;   // best[0] = 0
                        end
                    end
                end
                S_RD:
                begin
                    if (cusable) state_reg <= S_CMP;
                    else if (k_reg + 3'd1 == n_reg) state_reg <= S_WR;
                    else k_reg <= k_reg + 3'd1;
                end
                S_CMP:
                begin
                    if (rd_best != UNREACH && rd_best + 11'd1 < b_reg)
                    begin
                        b_reg  <= rd_best + 11'd1;
                        ch_reg <= k_reg;
                    end
                    if (k_reg + 3'd1 == n_reg) state_reg <= S_WR;
                    else
                    begin
                        k_reg     <= k_reg + 3'd1;
                        state_reg <= S_RD;
                    end
                end
                S_WR:
                begin
                    k_reg <= '0;
                    if (amt_reg == tgt_reg)
                    begin
                        if (b_reg != UNREACH)
                        begin
                            found_reg <= 1'b1;
                            left_reg  <= AMT_W'(tgt_reg);
                            state_reg <= (tgt_reg == '0) ? S_OUT : S_BTRD;
                        end
                        else state_reg <= S_OUT;
                    end
                    else
                    begin
                        amt_reg   <= amt_reg + EW'(1);
                        b_reg     <= UNREACH;
                        ch_reg    <= '0;
                        state_reg <= S_RD;
                    end
                end
                S_BTRD: state_reg <= S_BTUP;
                S_BTUP:
                begin
                    if (int'(rd_ch) >= REG_COINS) state_reg <= S_OUT;
                    else
                    begin
                        tally_reg[rd_ch] <= tally_reg[rd_ch] + AMT_W'(1);
                        left_reg <= left_reg - bt_val;
                        state_reg <= (left_reg - bt_val == '0) ? S_OUT : S_BTRD;
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        if (k_reg + 3'd1 == n_reg) state_reg <= S_IDLE;
                        else k_reg <= k_reg + 3'd1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

>>> bench/testbench.sv
// Self-checking bench for min_coin_change_solver: directed table, then random phases.
// Depends on mcc_pkg and the solver RTL; needs nothing else.
module testbench;
    import mcc_pkg::*;

    // Register map: index 0 is the coin count, 1..6 the coin values, 7 is unmapped.
    localparam logic [CNT_W-1:0] REG_VAL0 = 3'd1;
    localparam logic [CNT_W-1:0] REG_NONE = 3'd7;
    localparam int CYCLE_LIMIT = 20000000;
    localparam int HOLD_CYCLES = 400;

    // How a directed row is checked: by the predictor, or by a result typed in here.
    typedef enum logic [1:0] {CHK_PREDICT, CHK_ZERO_MADE, CHK_UNREACH} chk_kind_t;

    typedef struct packed {
        logic             is_cfg;
        logic [CNT_W-1:0] idx;
        logic [AMT_W-1:0] val;
        chk_kind_t        chk;
    } row_t;

    typedef struct packed {
        logic [CNT_W-1:0] coin_index;
        logic [AMT_W-1:0] coin_uses;
        logic             found;
        logic             last;
    } tally_t;

    localparam int NUM_ROWS = 31;
    localparam row_t DIRECTED [NUM_ROWS] = '{
        // reset setup: one coin of value 1
        '{1'b0, 3'd0, 10'd0,    CHK_ZERO_MADE},
        '{1'b0, 3'd0, 10'd1023, CHK_PREDICT},
        '{1'b0, 3'd0, 10'd5,    CHK_PREDICT},
        // six coins, extremes of value
        '{1'b1, REG_COUNT, 10'd6,    CHK_PREDICT},
        '{1'b1, 3'd1,      10'd1,    CHK_PREDICT},
        '{1'b1, 3'd2,      10'd5,    CHK_PREDICT},
        '{1'b1, 3'd3,      10'd10,   CHK_PREDICT},
        '{1'b1, 3'd4,      10'd25,   CHK_PREDICT},
        '{1'b1, 3'd5,      10'd50,   CHK_PREDICT},
        '{1'b1, 3'd6,      10'd1023, CHK_PREDICT},
        '{1'b0, 3'd0, 10'd0,    CHK_ZERO_MADE},
        '{1'b0, 3'd0, 10'd1023, CHK_PREDICT},
        '{1'b0, 3'd0, 10'd99,   CHK_PREDICT},
        '{1'b0, 3'd0, 10'd1022, CHK_PREDICT},
        // zero-valued coin, gaps: 4 and 6 only reach even amounts
        '{1'b1, REG_COUNT, 10'd3, CHK_PREDICT},
        '{1'b1, 3'd1,      10'd0, CHK_PREDICT},
        '{1'b1, 3'd2,      10'd4, CHK_PREDICT},
        '{1'b1, 3'd3,      10'd6, CHK_PREDICT},
        '{1'b0, 3'd0, 10'd1,  CHK_UNREACH},
        '{1'b0, 3'd0, 10'd7,  CHK_UNREACH},
        '{1'b0, 3'd0, 10'd22, CHK_PREDICT},
        // equal coins: tie goes to the lower index
        '{1'b1, 3'd1, 10'd4, CHK_PREDICT},
        '{1'b0, 3'd0, 10'd16, CHK_PREDICT},
        // count above six saturates; upper data bits are dropped
        '{1'b1, REG_COUNT, 10'd7, CHK_PREDICT},
        '{1'b0, 3'd0, 10'd12, CHK_PREDICT},
        '{1'b1, REG_COUNT, 10'h3FD, CHK_PREDICT},
        '{1'b1, REG_NONE,  10'h3FF, CHK_PREDICT},
        '{1'b0, 3'd0, 10'd20, CHK_PREDICT},
        // count zero: no results at all
        '{1'b1, REG_COUNT, 10'd0, CHK_PREDICT},
        '{1'b0, 3'd0, 10'd5,  CHK_PREDICT},
        '{1'b0, 3'd0, 10'd0,  CHK_PREDICT}
    };

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [AMT_W-1:0] target_amount = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [CNT_W-1:0] coin_index;
    logic [AMT_W-1:0] coin_uses;
    logic             found;
    logic             last;
    logic             cfg_we = 1'b0;
    logic [CNT_W-1:0] cfg_index = '0;
    logic [AMT_W-1:0] cfg_data = '0;

    min_coin_change_solver i_dut (.*);

    always #6 clk = ~clk;

    // Shadow of the register file, used by the change predictor.
    logic [CNT_W-1:0] sh_count;
    logic [AMT_W-1:0] sh_value [REG_COINS];

    tally_t pending_tallies [$];
    int     fill_best   [0:1023];
    int     fill_choice [0:1023];

    int errors;
    int items_sent;
    int results_seen;
    int cfg_writes;
    int cycles;
    int last_target;
    bit idle_on;      // when clear, neither side inserts gaps
    bit hold_req;     // asks the receiver for one long hold-off

    task automatic report(input string what, input int expd, input int got);
        errors++;
        $display("ERROR @%0t: %s expected %0d got %0d", $realtime, what, expd, got);
    endtask

    function automatic int active_coins();
        return (int'(sh_count) > REG_COINS) ? REG_COINS : int'(sh_count);
    endfunction

    // Fewest-coin table fill, lowest index wins ties, then backtrack to tallies.
    function automatic void predict_change(input logic [AMT_W-1:0] amt);
        int n;
        int b;
        int ch;
        int c;
        int left;
        bit made;
        logic [AMT_W-1:0] tally [REG_COINS];
        tally_t r;
        n = active_coins();
        for (int k = 0; k < REG_COINS; k++) tally[k] = '0;
        fill_best[0] = 0;
        fill_choice[0] = 0;
        for (int a = 1; a <= int'(amt); a++) begin
            b = int'(UNREACH);
            ch = 0;
            for (int k = 0; k < n; k++) begin
                c = int'(sh_value[k]);
                if (c != 0 && c <= a && fill_best[a-c] != int'(UNREACH)
                    && fill_best[a-c] + 1 < b)
                begin
                    b = fill_best[a-c] + 1;
                    ch = k;
                end
            end
            fill_best[a] = b;
            fill_choice[a] = ch;
        end
        made = (fill_best[amt] != int'(UNREACH));
        if (made) begin
            left = int'(amt);
            while (left != 0) begin
                tally[fill_choice[left]] = tally[fill_choice[left]] + 1'b1;
                left = left - int'(sh_value[fill_choice[left]]);
            end
        end
        for (int k = 0; k < n; k++) begin
            r.coin_index = CNT_W'(k);
            r.coin_uses  = made ? tally[k] : '0;
            r.found      = made;
            r.last       = (k == n - 1);
            pending_tallies.push_back(r);
        end
    endfunction

    // Expectation typed in by hand: every count zero, with the given found flag.
    function automatic void expect_all_zero(input logic made);
        tally_t r;
        for (int k = 0; k < active_coins(); k++) begin
            r.coin_index = CNT_W'(k);
            r.coin_uses  = '0;
            r.found      = made;
            r.last       = (k == active_coins() - 1);
            pending_tallies.push_back(r);
        end
    endfunction

    function automatic int draw_gap();
        return idle_on ? $urandom_range(0, 17) : 0;
    endfunction

    // Waits until all results are in, then long enough for a result-less item to finish.
    task automatic drain();
        while (pending_tallies.size() != 0) @(posedge clk);
        repeat (14 * last_target + 64) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CNT_W-1:0] idx, input logic [AMT_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_COUNT) sh_count = val[CNT_W-1:0];
        else if (idx <= REG_COINS) sh_value[idx - 1] = val;
        cfg_writes++;
    endtask

    // One input transfer; valid stays up across back-to-back items.
    task automatic send_target(input logic [AMT_W-1:0] amt, input chk_kind_t chk);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        target_amount <= amt;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        case (chk)
            CHK_ZERO_MADE: expect_all_zero(1'b1);
            CHK_UNREACH:   expect_all_zero(1'b0);
            default:       predict_change(amt);
        endcase
        items_sent++;
        last_target = int'(amt);
    endtask

    task automatic end_items();
        in_valid <= 1'b0;
    endtask

    function automatic logic [AMT_W-1:0] rand_target();
        int p;
        p = $urandom_range(0, 99);
        if (p < 85) return AMT_W'($urandom_range(0, 63));
        if (p < 95) return AMT_W'($urandom_range(64, 255));
        return AMT_W'($urandom_range(768, 1023));
    endfunction

    function automatic logic [AMT_W-1:0] rand_coin();
        int p;
        p = $urandom_range(0, 99);
        if (p < 8) return '0;
        if (p < 14) return 10'd1023;
        if (p < 20) return AMT_W'($urandom);
        return AMT_W'($urandom_range(1, 20));
    endfunction

    // Receiver: random stall per result, plus one long hold-off on request.
    initial begin
        int n;
        forever begin
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end else begin
                n = draw_gap();
                if (n > 0) begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
            @(posedge clk);
            while (!(out_valid && !out_stall) && !hold_req) @(posedge clk);
        end
    end

    // Result checker: values sampled at the edge, before the block updates them.
    always @(posedge clk) begin
        tally_t e;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (pending_tallies.size() == 0) begin
                report("unexpected result, coin_index", -1, int'(coin_index));
            end else begin
                e = pending_tallies.pop_front();
                if (coin_index !== e.coin_index)
                    report("coin_index", int'(e.coin_index), int'(coin_index));
                if (coin_uses !== e.coin_uses)
                    report("coin_uses", int'(e.coin_uses), int'(coin_uses));
                if (found !== e.found) report("found", int'(e.found), int'(found));
                if (last !== e.last) report("last", int'(e.last), int'(last));
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        logic [AMT_W-1:0] cnt;
        sh_count = 3'd1;
        for (int k = 0; k < REG_COINS; k++) sh_value[k] = 10'd1;
        idle_on = 1'b1;
        hold_req = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table; registers only change once the block has gone quiet.
        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].is_cfg) begin
                end_items();
                drain();
                write_reg(DIRECTED[i].idx, DIRECTED[i].val);
            end else begin
                send_target(DIRECTED[i].val, DIRECTED[i].chk);
            end
        end

        // Random phases: fresh coin set each time, one with no idling, one with hold-off.
        for (int ph = 0; ph < 6; ph++) begin
            end_items();
            drain();
            case (ph)
                0: cnt = 10'd6;
                1: cnt = 10'd1;
                default: cnt = ($urandom_range(0, 9) == 0) ? AMT_W'($urandom_range(0, 7))
                                                           : AMT_W'($urandom_range(1, 6));
            endcase
            write_reg(REG_COUNT, cnt);
            for (int k = 0; k < REG_COINS; k++)
                write_reg(CNT_W'(int'(REG_VAL0) + k), rand_coin());
            idle_on = (ph != 2);
            if (ph == 3) hold_req = 1'b1;
            for (int i = 0; i < 14; i++) send_target(rand_target(), CHK_PREDICT);
        end
        end_items();
        while (pending_tallies.size() != 0) @(posedge clk);
        repeat (14 * last_target + 64) @(posedge clk);

        $display("covered %0d targets, %0d coin tallies, %0d register writes",
                 items_sent, results_seen, cfg_writes);
        if (errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
